/* rtl/sws_pkg.sv */
// shared types, constants and codes of the stroke window statistics core
`default_nettype none

package sws_pkg;

	// default ring depth
	localparam int MAX_WINDOW_DEF = 32;

	// configuration port
	localparam int PADDR_W = 3;
	localparam logic REG_WINDOW_LENGTH = 1'b0;
	localparam logic [5:0] WINDOW_LENGTH_RST = 6'd32;

	// ring entry: x, y, major radius, contact size
	localparam int RAM_W = 80;

	typedef struct packed {
		logic [15:0] point_x;
		logic [15:0] point_y;
		logic [15:0] radius_major;
		logic [15:0] radius_minor;
		logic [15:0] touch_id;
	} sample_t;

	typedef struct packed {
		logic [15:0] centroid_x;
		logic [15:0] centroid_y;
		logic [15:0] max_major;
		logic [31:0] biggest_area;
		logic [5:0]  window_fill;
		logic [31:0] total_seen;
		logic [15:0] stroke_id;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_WRITE,
		ST_WALK,
		ST_DRAIN,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic capture;
		logic mul;
		logic write;
		logic issue;
		logic div_step;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic walk_last;
		logic div_last;
		logic out_busy;
	} sts_t;

endpackage

`default_nettype wire

/* rtl/sws_sample_if.sv */
// valid/ready channel that carries one touch sample
`default_nettype none

interface sws_sample_if;
	logic             valid;
	logic             ready;
	sws_pkg::sample_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/sws_result_if.sv */
// valid/ready channel that carries one window statistics result
`default_nettype none

interface sws_result_if;
	logic             valid;
	logic             ready;
	sws_pkg::result_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/stroke_window_statistics_core.sv */
// top level of the stroke window statistics core: config register, controller and datapath
`default_nettype none

// Takes one touch sample per transfer on the sample channel and returns one result per
// sample on the result channel: window mean of x and y (truncated), largest major radius,
// largest contact size, window fill, saturating sample count and the stroke id latched from
// the first sample after reset. One sample is worked at a time; its time from transfer to
// the valid result is set by the walk over the ring, which reads the window fill entries one
// entry per cycle through the single read port of the ring memory, and by the bit-serial
// divider that produces both centroids together, one quotient bit per cycle over SW =
// log2(MAX_WINDOW * 65536) bits (21 at the default depth). The next sample is taken as
// soon as the controller is back in idle, even while the previous result still waits in the
// output register. The ring needs no clearing pass after reset: the walk only covers entries
// written since reset. window_length sits at byte address 0 of the config port; zero acts as
// one and values above MAX_WINDOW act as MAX_WINDOW; change it only while the core is idle.
module stroke_window_statistics_core #(
	parameter int MAX_WINDOW = sws_pkg::MAX_WINDOW_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	sws_sample_if.sink                       sample,
	sws_result_if.source                     result,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [sws_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic      [31:0]                 prdata,
	output logic                             pready
);

	// config register
	logic [5:0] window_length_q;
	logic       cfg_wr;
	logic       cfg_hit;

	sws_pkg::cmd_t cmd;
	sws_pkg::sts_t sts;

	// byte offset bits are ignored, index is the word address
	assign cfg_hit = (paddr[2] == sws_pkg::REG_WINDOW_LENGTH);
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;
	assign prdata  = cfg_hit ? {26'd0, window_length_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q <= sws_pkg::WINDOW_LENGTH_RST;
		end else if (cfg_wr) begin
			window_length_q <= pwdata[5:0];
		end
	end

	// sequencer
	sws_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_valid(sample.valid),
		.sample_ready(sample.ready),
		.sts         (sts),
		.cmd         (cmd)
	);

	// ring, walk, divider and output register
	sws_dpath #(
		.MAX_WINDOW(MAX_WINDOW)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.window_length(window_length_q),
		.sample_data  (sample.data),
		.result_data  (result.data),
		.result_valid (result.valid),
		.result_ready (result.ready)
	);

	// a sample transfer always moves the controller out of idle
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(sample.valid && sample.ready) |=> !sample.ready)
		else $error("sample taken while previous sample still in work");

	// a fresh result appears exactly as the controller returns to idle
	a_idle_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> sample.ready)
		else $error("result raised without return to idle");

	// every result covers at least one sample
	a_result_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.data.window_fill != 6'd0 && result.data.total_seen != 32'd0))
		else $error("result with empty window");

endmodule

`default_nettype wire

/* rtl/sws_ram.sv */
// generic single write port, single read port ram with registered read
`default_nettype none

module sws_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/sws_ctrl.sv */
// sequencing state machine: capture, size multiply, ring write, walk, divide, result
`default_nettype none

module sws_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          sample_valid,
	output logic               sample_ready,
	input  wire sws_pkg::sts_t sts,
	output sws_pkg::cmd_t      cmd
);

	sws_pkg::state_t state_q;
	sws_pkg::state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sws_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			sws_pkg::ST_IDLE: begin
				if (sample_valid) begin
					state_nx = sws_pkg::ST_MUL;
				end
			end
			sws_pkg::ST_MUL:   state_nx = sws_pkg::ST_WRITE;
			sws_pkg::ST_WRITE: state_nx = sws_pkg::ST_WALK;
			sws_pkg::ST_WALK: begin
				if (sts.walk_last) begin
					state_nx = sws_pkg::ST_DRAIN;
				end
			end
			sws_pkg::ST_DRAIN: state_nx = sws_pkg::ST_DIV;
			sws_pkg::ST_DIV: begin
				if (sts.div_last) begin
					state_nx = sws_pkg::ST_DONE;
				end
			end
			sws_pkg::ST_DONE: begin
				if (!sts.out_busy) begin
					state_nx = sws_pkg::ST_IDLE;
				end
			end
			default: state_nx = sws_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		sample_ready = 1'b0;
		case (state_q)
			sws_pkg::ST_IDLE: begin
				sample_ready = 1'b1;
				cmd.capture  = sample_valid;
			end
			sws_pkg::ST_MUL:   cmd.mul = 1'b1;
			sws_pkg::ST_WRITE: cmd.write = 1'b1;
			sws_pkg::ST_WALK:  cmd.issue = 1'b1;
			sws_pkg::ST_DRAIN: ;
			sws_pkg::ST_DIV:   cmd.div_step = 1'b1;
			sws_pkg::ST_DONE:  cmd.load_out = !sts.out_busy;
			default: ;
		endcase
	end

endmodule

`default_nettype wire

/* rtl/sws_dpath.sv */
// datapath: sample registers, size multiplier, ring, window walk, serial divider, result register
`default_nettype none

module sws_dpath #(
	parameter int MAX_WINDOW = sws_pkg::MAX_WINDOW_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire sws_pkg::cmd_t    cmd,
	output sws_pkg::sts_t         sts,
	input  wire logic [5:0]       window_length,
	input  wire sws_pkg::sample_t sample_data,
	output sws_pkg::result_t      result_data,
	output logic                  result_valid,
	input  wire logic             result_ready
);

	localparam int AW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int FW  = $clog2(MAX_WINDOW + 1);
	localparam int SW  = $clog2(MAX_WINDOW * 65536);
	localparam int SCW = $clog2(SW);

	sws_pkg::sample_t smp_q;
	logic [31:0]      area_q;
	logic [15:0]      mul_b;
	logic [31:0]      area_prod;

	logic [AW-1:0] head_q;
	logic [AW-1:0] rp_q;
	logic [FW-1:0] cnt_q;
	logic [FW-1:0] fill_q;
	logic [FW-1:0] len_eff;
	logic [FW:0]   fill_inc;
	logic [FW-1:0] fill_nx;
	logic [31:0]   seen_q;
	logic [15:0]   id_q;
	logic          pend_q;

	logic [SW-1:0]  sx_q;
	logic [SW-1:0]  sy_q;
	logic [15:0]    mx_q;
	logic [31:0]    ma_q;
	logic [FW-1:0]  rx_q;
	logic [FW-1:0]  ry_q;
	logic [SCW-1:0] step_q;

	logic [FW:0] rx_sh;
	logic [FW:0] ry_sh;
	logic        gx;
	logic        gy;

	logic [sws_pkg::RAM_W-1:0] ram_wdata;
	logic [sws_pkg::RAM_W-1:0] ram_rdata;
	logic [15:0]               rd_x;
	logic [15:0]               rd_y;
	logic [15:0]               rd_maj;
	logic [31:0]               rd_area;

	sws_pkg::result_t res_q;
	logic             out_valid_q;
	logic [FW+5:0]    fill_ext;

	// effective window length: zero means one, clamp to ring depth
	always_comb begin
		if (window_length == 6'd0) begin
			len_eff = FW'(1);
		end else if (32'(window_length) > 32'(MAX_WINDOW)) begin
			len_eff = FW'(MAX_WINDOW);
		end else begin
			len_eff = FW'(window_length);
		end
	end

	assign fill_inc = {1'b0, fill_q} + (FW+1)'(1);
	assign fill_nx  = (fill_inc > {1'b0, len_eff}) ? len_eff : fill_inc[FW-1:0];

	// contact size: major times minor, major squared when minor is unreported
	assign mul_b     = (smp_q.radius_minor == 16'd0) ? smp_q.radius_major : smp_q.radius_minor;
	assign area_prod = 32'(smp_q.radius_major) * 32'(mul_b);

	assign ram_wdata = {smp_q.point_x, smp_q.point_y, smp_q.radius_major, area_q};
	assign rd_x      = ram_rdata[79:64];
	assign rd_y      = ram_rdata[63:48];
	assign rd_maj    = ram_rdata[47:32];
	assign rd_area   = ram_rdata[31:0];

	sws_ram #(
		.WIDTH(sws_pkg::RAM_W),
		.DEPTH(MAX_WINDOW)
	) u_ring (
		.clk  (clk),
		.we   (cmd.write),
		.waddr(head_q),
		.wdata(ram_wdata),
		.re   (cmd.issue),
		.raddr(rp_q),
		.rdata(ram_rdata)
	);

	// restoring divide, one quotient bit per step for both axes
	assign rx_sh = {rx_q, sx_q[SW-1]};
	assign ry_sh = {ry_q, sy_q[SW-1]};
	assign gx    = rx_sh >= {1'b0, fill_q};
	assign gy    = ry_sh >= {1'b0, fill_q};

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			smp_q <= sample_data;
		end
		if (cmd.mul) begin
			area_q <= area_prod;
		end
		if (cmd.write) begin
			sx_q <= '0;
			sy_q <= '0;
			mx_q <= '0;
			ma_q <= '0;
			rx_q <= '0;
			ry_q <= '0;
		end else if (pend_q) begin
			sx_q <= sx_q + SW'(rd_x);
			sy_q <= sy_q + SW'(rd_y);
			if (rd_maj > mx_q) begin
				mx_q <= rd_maj;
			end
			if (rd_area > ma_q) begin
				ma_q <= rd_area;
			end
		end else if (cmd.div_step) begin
			rx_q <= gx ? FW'(rx_sh - {1'b0, fill_q}) : rx_sh[FW-1:0];
			ry_q <= gy ? FW'(ry_sh - {1'b0, fill_q}) : ry_sh[FW-1:0];
			sx_q <= {sx_q[SW-2:0], gx};
			sy_q <= {sy_q[SW-2:0], gy};
		end
		if (cmd.load_out) begin
			res_q.centroid_x   <= sx_q[15:0];
			res_q.centroid_y   <= sy_q[15:0];
			res_q.max_major    <= mx_q;
			res_q.biggest_area <= ma_q;
			res_q.window_fill  <= fill_ext[5:0];
			res_q.total_seen   <= seen_q;
			res_q.stroke_id    <= id_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			rp_q        <= '0;
			cnt_q       <= '0;
			fill_q      <= '0;
			seen_q      <= '0;
			id_q        <= '0;
			pend_q      <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			pend_q <= cmd.issue;
			if (cmd.write) begin
				head_q <= (head_q == AW'(MAX_WINDOW - 1)) ? '0 : head_q + AW'(1);
				rp_q   <= head_q;
				cnt_q  <= '0;
				fill_q <= fill_nx;
				step_q <= '0;
				if (seen_q != '1) begin
					seen_q <= seen_q + 32'd1;
				end
				if (fill_q == '0) begin
					id_q <= smp_q.touch_id;
				end
			end
			if (cmd.issue) begin
				rp_q  <= (rp_q == '0) ? AW'(MAX_WINDOW - 1) : rp_q - AW'(1);
				cnt_q <= cnt_q + FW'(1);
			end
			if (cmd.div_step) begin
				step_q <= step_q + SCW'(1);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign fill_ext = (FW+6)'(fill_q);

	assign sts.walk_last = (FW'(cnt_q + FW'(1)) == fill_q);
	assign sts.div_last  = (step_q == SCW'(SW - 1));
	assign sts.out_busy  = out_valid_q && !result_ready;

	assign result_data  = res_q;
	assign result_valid = out_valid_q;

endmodule

`default_nettype wire
